// ===== design/mcfc_pkg.sv =====
package mcfc_pkg;

  typedef enum logic {
    KIND_PACK   = 1'b0,
    KIND_UNPACK = 1'b1
  } kind_t;

  localparam int unsigned FRAME_W = 64;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned POS_W   = 21;
  localparam int unsigned VEL_W   = 23;
  localparam int unsigned KP_W    = 25;
  localparam int unsigned KD_W    = 19;
  localparam int unsigned TRQ_W   = 21;

  localparam logic [20:0] POS_SPAN = 21'd1638400;
  localparam logic [22:0] VEL_SPAN = 23'd5898240;
  localparam logic [24:0] KP_SPAN  = 25'd32768000;
  localparam logic [18:0] KD_SPAN  = 19'd327680;
  localparam logic [20:0] TRQ_SPAN = 21'd1966080;

  localparam logic [20:0] POS_OFS = 21'd819200;
  localparam logic [21:0] VEL_OFS = 22'd2949120;
  localparam logic [19:0] TRQ_OFS = 20'd983040;

  localparam logic [21:0] POS_RCP = 22'd2684355;
  localparam logic [18:0] VEL_RCP = 19'd372828;
  localparam logic [19:0] KP_RCP  = 20'd536871;
  localparam logic [14:0] KD_RCP  = 15'd26215;
  localparam logic [16:0] TRQ_RCP = 17'd69906;

  localparam logic [4:0] POS_K = 5'd25;
  localparam logic [5:0] VEL_K = 6'd45;
  localparam logic [3:0] TRQ_K = 4'd15;

  localparam logic [15:0] CODE16_MAX = 16'hFFFF;
  localparam logic [11:0] CODE12_MAX = 12'hFFF;

endpackage

// ===== design/motor_can_frame_codec_core.sv =====
// Motor CAN frame codec.
// One request on the in_ channel carries a kind bit and the fields of both
// directions. Kind pack saturates the five command values to their ranges,
// quantises them and presents the packed 64-bit command frame; the reply
// fields of the result are then zero. Kind unpack splits the 64-bit reply
// frame into id, position, velocity, torque, temperature and fault byte and
// scales the three codes back to Q16.16; the command frame is then zero.
// Each request gives exactly one result on the out_ channel.
// A request passes an input register, an intermediate register and the
// result register, in that order.
// One request is accepted in every cycle while the result side keeps up.
// When out_stall is high the result holds; the two earlier registers still
// fill, and in_stall rises only once all three hold waiting requests.
// Reset empties all three registers; no result is pending afterwards.
module motor_can_frame_codec_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_kind,
  input  logic signed [20:0]  in_cmd_position,
  input  logic signed [22:0]  in_cmd_velocity,
  input  logic        [24:0]  in_cmd_stiffness,
  input  logic        [18:0]  in_cmd_damping,
  input  logic signed [20:0]  in_cmd_torque,
  input  logic        [63:0]  in_reply_frame,
  output logic                out_valid,
  input  logic                out_stall,
  output logic        [63:0]  out_command_frame,
  output logic        [7:0]   out_node_id,
  output logic signed [20:0]  out_meas_position,
  output logic signed [22:0]  out_meas_velocity,
  output logic signed [20:0]  out_meas_torque,
  output logic        [7:0]   out_temperature,
  output logic        [7:0]   out_fault_code
);

  logic adv3, adv2, adv1;

  logic                s1_valid_r;
  mcfc_pkg::kind_t     s1_kind_r;
  logic signed [20:0]  s1_pos_r;
  logic signed [22:0]  s1_vel_r;
  logic        [24:0]  s1_kp_r;
  logic        [18:0]  s1_kd_r;
  logic signed [20:0]  s1_trq_r;
  logic        [63:0]  s1_reply_r;

  logic                s2_valid_r;
  mcfc_pkg::kind_t     s2_kind_r;
  logic        [20:0]  s2_pos_n1_r, s2_pos_n1_nxt;
  logic        [17:0]  s2_vel_n1_r, s2_vel_n1_nxt;
  logic        [18:0]  s2_kp_n1_r,  s2_kp_n1_nxt;
  logic        [14:0]  s2_kd_n1_r,  s2_kd_n1_nxt;
  logic        [15:0]  s2_trq_n1_r, s2_trq_n1_nxt;
  logic        [20:0]  s2_rpos_u_r, s2_rpos_u_nxt;
  logic        [22:0]  s2_rvel_u_r, s2_rvel_u_nxt;
  logic        [20:0]  s2_rtrq_u_r, s2_rtrq_u_nxt;
  logic        [23:0]  s2_bytes_r;

  logic                out_valid_r;
  logic        [63:0]  frame_r, frame_nxt;
  logic        [7:0]   id_r, id_nxt;
  logic signed [20:0]  mpos_r, mpos_nxt;
  logic signed [22:0]  mvel_r, mvel_nxt;
  logic signed [20:0]  mtrq_r, mtrq_nxt;
  logic        [7:0]   temp_r, temp_nxt;
  logic        [7:0]   fault_r, fault_nxt;

  // Handshake: a stage advances when the stage after it is empty or moving.
  assign adv3     = !out_valid_r || !out_stall;
  assign adv2     = !s2_valid_r || adv3;
  assign adv1     = !s1_valid_r || adv2;
  assign in_stall = !adv1;

  // Stage two: saturation and the power-of-two part of the quantiser, and the
  // scaling products of the reply codes.
  logic signed [21:0] pos_d, trq_d;
  logic signed [23:0] vel_d;
  logic        [20:0] pos_c, trq_c;
  logic        [22:0] vel_c;
  logic        [24:0] kp_c;
  logic        [18:0] kd_c;
  logic        [36:0] pos_dm, kp_dm;
  logic        [34:0] vel_dm;
  logic        [30:0] kd_dm;
  logic        [32:0] trq_dm;
  logic        [17:0] rvel_t;
  logic        [15:0] rtrq_t;

  always_comb begin
    pos_d = 22'(s1_pos_r) + $signed({1'b0, mcfc_pkg::POS_OFS});
    vel_d = 24'(s1_vel_r) + $signed({2'b0, mcfc_pkg::VEL_OFS});
    trq_d = 22'(s1_trq_r) + $signed({2'b0, mcfc_pkg::TRQ_OFS});

    if (pos_d[21]) begin
      pos_c = '0;
    end else if (pos_d[20:0] > mcfc_pkg::POS_SPAN) begin
      pos_c = mcfc_pkg::POS_SPAN;
    end else begin
      pos_c = pos_d[20:0];
    end
    if (vel_d[23]) begin
      vel_c = '0;
    end else if (vel_d[22:0] > mcfc_pkg::VEL_SPAN) begin
      vel_c = mcfc_pkg::VEL_SPAN;
    end else begin
      vel_c = vel_d[22:0];
    end
    if (trq_d[21]) begin
      trq_c = '0;
    end else if (trq_d[20:0] > mcfc_pkg::TRQ_SPAN) begin
      trq_c = mcfc_pkg::TRQ_SPAN;
    end else begin
      trq_c = trq_d[20:0];
    end
    kp_c = (s1_kp_r > mcfc_pkg::KP_SPAN) ? mcfc_pkg::KP_SPAN : s1_kp_r;
    kd_c = (s1_kd_r > mcfc_pkg::KD_SPAN) ? mcfc_pkg::KD_SPAN : s1_kd_r;

    // The code range times the offset value, taken as a shift and a subtract.
    pos_dm = {pos_c, 16'b0} - {16'b0, pos_c};
    vel_dm = {vel_c, 12'b0} - {12'b0, vel_c};
    kp_dm  = {kp_c, 12'b0}  - {12'b0, kp_c};
    kd_dm  = {kd_c, 12'b0}  - {12'b0, kd_c};
    trq_dm = {trq_c, 12'b0} - {12'b0, trq_c};

    s2_pos_n1_nxt = pos_dm[36:16];
    s2_vel_n1_nxt = vel_dm[34:17];
    s2_kp_n1_nxt  = kp_dm[36:18];
    s2_kd_n1_nxt  = kd_dm[30:16];
    s2_trq_n1_nxt = trq_dm[32:17];

    s2_rpos_u_nxt = 21'(s1_reply_r[55:40]) * 21'(mcfc_pkg::POS_K);
    rvel_t        = 18'(s1_reply_r[39:28]) * 18'(mcfc_pkg::VEL_K);
    rtrq_t        = 16'(s1_reply_r[27:16]) * 16'(mcfc_pkg::TRQ_K);
    s2_rvel_u_nxt = {rvel_t, 5'b0};
    s2_rtrq_u_nxt = {rtrq_t, 5'b0};
  end

  // Stage three: the odd part of each divisor by reciprocal multiplication,
  // and division of the reply products by the code range with one correction.
  logic [42:0] pos_prod;
  logic [36:0] vel_prod;
  logic [38:0] kp_prod;
  logic [29:0] kd_prod;
  logic [32:0] trq_prod;
  logic [4:0]  rpos_qa;
  logic [10:0] rvel_qa;
  logic [8:0]  rtrq_qa;
  logic [16:0] rpos_ra;
  logic [12:0] rvel_ra, rtrq_ra;
  logic [21:0] rpos_res, rtrq_res;
  logic [23:0] rvel_res;

  always_comb begin
    pos_prod = 43'(s2_pos_n1_r) * 43'(mcfc_pkg::POS_RCP);
    vel_prod = 37'(s2_vel_n1_r) * 37'(mcfc_pkg::VEL_RCP);
    kp_prod  = 39'(s2_kp_n1_r)  * 39'(mcfc_pkg::KP_RCP);
    kd_prod  = 30'(s2_kd_n1_r)  * 30'(mcfc_pkg::KD_RCP);
    trq_prod = 33'(s2_trq_n1_r) * 33'(mcfc_pkg::TRQ_RCP);

    rpos_qa  = s2_rpos_u_r[20:16];
    rpos_ra  = {1'b0, s2_rpos_u_r[15:0]} + 17'(rpos_qa);
    rpos_res = 22'(s2_rpos_u_r) + 22'(rpos_qa)
             + 22'(rpos_ra >= 17'(mcfc_pkg::CODE16_MAX));

    rvel_qa  = s2_rvel_u_r[22:12];
    rvel_ra  = {1'b0, s2_rvel_u_r[11:0]} + 13'(rvel_qa);
    rvel_res = 24'(s2_rvel_u_r) + 24'(rvel_qa)
             + 24'(rvel_ra >= 13'(mcfc_pkg::CODE12_MAX));

    rtrq_qa  = s2_rtrq_u_r[20:12];
    rtrq_ra  = {1'b0, s2_rtrq_u_r[11:0]} + 13'(rtrq_qa);
    rtrq_res = 22'(s2_rtrq_u_r) + 22'(rtrq_qa)
             + 22'(rtrq_ra >= 13'(mcfc_pkg::CODE12_MAX));

    frame_nxt = '0;
    id_nxt    = '0;
    mpos_nxt  = '0;
    mvel_nxt  = '0;
    mtrq_nxt  = '0;
    temp_nxt  = '0;
    fault_nxt = '0;
    unique case (s2_kind_r)
      mcfc_pkg::KIND_PACK: begin
        frame_nxt = {pos_prod[41:26], vel_prod[35:24], kp_prod[37:26],
                     kd_prod[28:17], trq_prod[31:20]};
      end
      mcfc_pkg::KIND_UNPACK: begin
        id_nxt    = s2_bytes_r[23:16];
        mpos_nxt  = 21'(rpos_res - 22'(mcfc_pkg::POS_OFS));
        mvel_nxt  = 23'(rvel_res - 24'(mcfc_pkg::VEL_OFS));
        mtrq_nxt  = 21'(rtrq_res - 22'(mcfc_pkg::TRQ_OFS));
        temp_nxt  = s2_bytes_r[15:8];
        fault_nxt = s2_bytes_r[7:0];
      end
      default: begin
        frame_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv1) begin
        s1_valid_r <= in_valid;
      end
      if (adv2) begin
        s2_valid_r <= s1_valid_r;
      end
      if (adv3) begin
        out_valid_r <= s2_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && adv1) begin
      s1_kind_r  <= mcfc_pkg::kind_t'(in_kind);
      s1_pos_r   <= in_cmd_position;
      s1_vel_r   <= in_cmd_velocity;
      s1_kp_r    <= in_cmd_stiffness;
      s1_kd_r    <= in_cmd_damping;
      s1_trq_r   <= in_cmd_torque;
      s1_reply_r <= in_reply_frame;
    end
    if (s1_valid_r && adv2) begin
      s2_kind_r   <= s1_kind_r;
      s2_pos_n1_r <= s2_pos_n1_nxt;
      s2_vel_n1_r <= s2_vel_n1_nxt;
      s2_kp_n1_r  <= s2_kp_n1_nxt;
      s2_kd_n1_r  <= s2_kd_n1_nxt;
      s2_trq_n1_r <= s2_trq_n1_nxt;
      s2_rpos_u_r <= s2_rpos_u_nxt;
      s2_rvel_u_r <= s2_rvel_u_nxt;
      s2_rtrq_u_r <= s2_rtrq_u_nxt;
      s2_bytes_r  <= {s1_reply_r[63:56], s1_reply_r[15:0]};
    end
    if (s2_valid_r && adv3) begin
      frame_r <= frame_nxt;
      id_r    <= id_nxt;
      mpos_r  <= mpos_nxt;
      mvel_r  <= mvel_nxt;
      mtrq_r  <= mtrq_nxt;
      temp_r  <= temp_nxt;
      fault_r <= fault_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_command_frame = frame_r;
  assign out_node_id       = id_r;
  assign out_meas_position = mpos_r;
  assign out_meas_velocity = mvel_r;
  assign out_meas_torque   = mtrq_r;
  assign out_temperature   = temp_r;
  assign out_fault_code    = fault_r;

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && s2_valid_r && out_valid_r && out_stall))
    else $error("input stalled while the pipeline has room");

  a_kinds_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (frame_r != 64'd0)) |->
      (id_r == 8'd0 && mpos_r == 21'sd0 && mvel_r == 23'sd0 && mtrq_r == 21'sd0
       && temp_r == 8'd0 && fault_r == 8'd0))
    else $error("result carries fields of both frame kinds");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (mpos_r >= -21'sd819200 && mpos_r <= 21'sd819200))
    else $error("decoded position out of range");

  a_vel_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (mvel_r >= -23'sd2949120 && mvel_r <= 23'sd2949120))
    else $error("decoded velocity out of range");

  a_trq_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (mtrq_r >= -21'sd983040 && mtrq_r <= 21'sd983040))
    else $error("decoded torque out of range");
`endif

endmodule

// ===== bench/tb_top.sv =====
module tb_top;

  localparam int IDLE_LIMIT  = 2000;
  localparam int HOLD_CYCLES = 64;
  localparam int MAX_REPORTS = 10;

  localparam longint POS_LO = -819200;
  localparam longint POS_HI = 819200;
  localparam longint VEL_LO = -2949120;
  localparam longint VEL_HI = 2949120;
  localparam longint KP_LO  = 0;
  localparam longint KP_HI  = 32768000;
  localparam longint KD_LO  = 0;
  localparam longint KD_HI  = 327680;
  localparam longint TRQ_LO = -983040;
  localparam longint TRQ_HI = 983040;

  typedef struct packed {
    mcfc_pkg::kind_t                     kind;
    logic signed [mcfc_pkg::POS_W-1:0]   pos;
    logic signed [mcfc_pkg::VEL_W-1:0]   vel;
    logic        [mcfc_pkg::KP_W-1:0]    kp;
    logic        [mcfc_pkg::KD_W-1:0]    kd;
    logic signed [mcfc_pkg::TRQ_W-1:0]   trq;
    logic        [mcfc_pkg::FRAME_W-1:0] reply;
  } request_t;

  typedef struct packed {
    logic [mcfc_pkg::FRAME_W-1:0] command_frame;
    logic [mcfc_pkg::BYTE_W-1:0]  node_id;
    logic [mcfc_pkg::POS_W-1:0]   meas_position;
    logic [mcfc_pkg::VEL_W-1:0]   meas_velocity;
    logic [mcfc_pkg::TRQ_W-1:0]   meas_torque;
    logic [mcfc_pkg::BYTE_W-1:0]  temperature;
    logic [mcfc_pkg::BYTE_W-1:0]  fault_code;
  } frame_result_t;

  typedef struct packed {
    request_t      req;
    logic          known;
    frame_result_t want;
  } stim_row_t;

  logic                clk              = 1'b0;
  logic                rst_n            = 1'b0;
  logic                in_valid         = 1'b0;
  logic                in_kind          = 1'b0;
  logic signed [20:0]  in_cmd_position  = '0;
  logic signed [22:0]  in_cmd_velocity  = '0;
  logic        [24:0]  in_cmd_stiffness = '0;
  logic        [18:0]  in_cmd_damping   = '0;
  logic signed [20:0]  in_cmd_torque    = '0;
  logic        [63:0]  in_reply_frame   = '0;
  logic                out_stall        = 1'b0;
  logic                in_stall;
  logic                out_valid;
  logic        [63:0]  out_command_frame;
  logic        [7:0]   out_node_id;
  logic signed [20:0]  out_meas_position;
  logic signed [22:0]  out_meas_velocity;
  logic signed [20:0]  out_meas_torque;
  logic        [7:0]   out_temperature;
  logic        [7:0]   out_fault_code;

  frame_result_t pending_results[$];
  stim_row_t     directed_rows[$];

  logic hold_off     = 1'b0;
  int   send_gap_pct = 0;
  int   stall_pct    = 0;
  int   n_errors     = 0;
  int   n_checked    = 0;
  int   n_pack       = 0;
  int   n_unpack     = 0;
  int   n_held       = 0;
  int   quiet_cycles = 0;

  motor_can_frame_codec_core u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_kind           (in_kind),
    .in_cmd_position   (in_cmd_position),
    .in_cmd_velocity   (in_cmd_velocity),
    .in_cmd_stiffness  (in_cmd_stiffness),
    .in_cmd_damping    (in_cmd_damping),
    .in_cmd_torque     (in_cmd_torque),
    .in_reply_frame    (in_reply_frame),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_command_frame (out_command_frame),
    .out_node_id       (out_node_id),
    .out_meas_position (out_meas_position),
    .out_meas_velocity (out_meas_velocity),
    .out_meas_torque   (out_meas_torque),
    .out_temperature   (out_temperature),
    .out_fault_code    (out_fault_code)
  );

  always #6 clk = ~clk;

  function automatic longint to_code(input longint x, input longint lo, input longint hi,
                                     input int bits);
    longint full;
    full = (longint'(1) << bits) - 1;
    if (x < lo) x = lo;
    if (x > hi) x = hi;
    return (x - lo) * full / (hi - lo);
  endfunction

  function automatic longint from_code(input longint code, input longint lo, input longint hi,
                                       input int bits);
    longint full;
    full = (longint'(1) << bits) - 1;
    return code * (hi - lo) / full + lo;
  endfunction

  function automatic frame_result_t codec_result(input request_t r);
    frame_result_t e;
    longint cp, cv, ckp, ckd, ct;
    e = '0;
    if (r.kind == mcfc_pkg::KIND_PACK) begin
      cp  = to_code(longint'($signed(r.pos)), POS_LO, POS_HI, 16);
      cv  = to_code(longint'($signed(r.vel)), VEL_LO, VEL_HI, 12);
      ckp = to_code(longint'(r.kp), KP_LO, KP_HI, 12);
      ckd = to_code(longint'(r.kd), KD_LO, KD_HI, 12);
      ct  = to_code(longint'($signed(r.trq)), TRQ_LO, TRQ_HI, 12);
      e.command_frame = 64'((cp << 48) | (cv << 36) | (ckp << 24) | (ckd << 12) | ct);
    end else begin
      e.node_id       = r.reply[63:56];
      e.meas_position = 21'(from_code(longint'(r.reply[55:40]), POS_LO, POS_HI, 16));
      e.meas_velocity = 23'(from_code(longint'(r.reply[39:28]), VEL_LO, VEL_HI, 12));
      e.meas_torque   = 21'(from_code(longint'(r.reply[27:16]), TRQ_LO, TRQ_HI, 12));
      e.temperature   = r.reply[15:8];
      e.fault_code    = r.reply[7:0];
    end
    return e;
  endfunction

  function automatic request_t pack_req(input longint p, input longint v, input longint kp,
                                        input longint kd, input longint t);
    request_t r;
    r      = '0;
    r.kind = mcfc_pkg::KIND_PACK;
    r.pos  = 21'(p);
    r.vel  = 23'(v);
    r.kp   = 25'(kp);
    r.kd   = 19'(kd);
    r.trq  = 21'(t);
    return r;
  endfunction

  function automatic request_t unpack_req(input logic [63:0] f);
    request_t r;
    r       = '0;
    r.kind  = mcfc_pkg::KIND_UNPACK;
    r.reply = f;
    return r;
  endfunction

  function automatic frame_result_t cmd_result(input logic [63:0] f);
    frame_result_t e;
    e               = '0;
    e.command_frame = f;
    return e;
  endfunction

  function automatic frame_result_t reply_result(input logic [7:0] id, input longint p,
                                                 input longint v, input longint t,
                                                 input logic [7:0] temp,
                                                 input logic [7:0] fault);
    frame_result_t e;
    e               = '0;
    e.node_id       = id;
    e.meas_position = 21'(p);
    e.meas_velocity = 23'(v);
    e.meas_torque   = 21'(t);
    e.temperature   = temp;
    e.fault_code    = fault;
    return e;
  endfunction

  function automatic longint pick_value(input longint lo, input longint hi);
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 60) return lo + longint'($urandom_range(32'(hi - lo)));
    if (sel < 80) begin
      case ($urandom_range(3))
        0: return lo;
        1: return hi;
        2: return lo - 1;
        default: return hi + 1;
      endcase
    end
    return longint'({$urandom(), $urandom()});
  endfunction

  function automatic request_t random_request();
    request_t r;
    logic bp, bv, bt;
    r.kind  = mcfc_pkg::kind_t'($urandom_range(1));
    r.pos   = 21'(pick_value(POS_LO, POS_HI));
    r.vel   = 23'(pick_value(VEL_LO, VEL_HI));
    r.kp    = 25'(pick_value(KP_LO, KP_HI));
    r.kd    = 19'(pick_value(KD_LO, KD_HI));
    r.trq   = 21'(pick_value(TRQ_LO, TRQ_HI));
    r.reply = {$urandom(), $urandom()};
    if ($urandom_range(3) == 0) begin
      bp = 1'($urandom_range(1));
      bv = 1'($urandom_range(1));
      bt = 1'($urandom_range(1));
      r.reply[55:40] = {16{bp}};
      r.reply[39:28] = {12{bv}};
      r.reply[27:16] = {12{bt}};
    end
    return r;
  endfunction

  task automatic add_row(input request_t r, input logic known, input frame_result_t want);
    stim_row_t row;
    row.req   = r;
    row.known = known;
    row.want  = want;
    directed_rows.push_back(row);
  endtask

  task automatic send_request(input request_t r, input logic known,
                              input frame_result_t typed);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_kind          <= r.kind;
    in_cmd_position  <= r.pos;
    in_cmd_velocity  <= r.vel;
    in_cmd_stiffness <= r.kp;
    in_cmd_damping   <= r.kd;
    in_cmd_torque    <= r.trq;
    in_reply_frame   <= r.reply;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(known ? typed : codec_result(r));
    if (r.kind == mcfc_pkg::KIND_PACK) n_pack++;
    else n_unpack++;
  endtask

  task automatic run_phase(input int n, input int gap_pct, input int stall_chance);
    send_gap_pct = gap_pct;
    stall_pct   <= stall_chance;
    repeat (n) send_request(random_request(), 1'b0, '0);
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      n_errors++;
      if (n_errors <= MAX_REPORTS)
        $display("Mismatch in %s of result %0d: expected %h, got %h",
                 name, n_checked, want, got);
    end
  endtask

  task automatic compare_result(input frame_result_t want, input frame_result_t got);
    check_field("command_frame", want.command_frame, got.command_frame);
    check_field("node_id", 64'(want.node_id), 64'(got.node_id));
    check_field("meas_position", 64'(want.meas_position), 64'(got.meas_position));
    check_field("meas_velocity", 64'(want.meas_velocity), 64'(got.meas_velocity));
    check_field("meas_torque", 64'(want.meas_torque), 64'(got.meas_torque));
    check_field("temperature", 64'(want.temperature), 64'(got.temperature));
    check_field("fault_code", 64'(want.fault_code), 64'(got.fault_code));
  endtask

  always @(posedge clk) begin
    frame_result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.command_frame = out_command_frame;
      got.node_id       = out_node_id;
      got.meas_position = out_meas_position;
      got.meas_velocity = out_meas_velocity;
      got.meas_torque   = out_meas_torque;
      got.temperature   = out_temperature;
      got.fault_code    = out_fault_code;
      if (pending_results.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS)
          $display("Result %h arrived with no request outstanding", got);
      end else begin
        compare_result(pending_results.pop_front(), got);
      end
      n_checked++;
    end
    if (rst_n && in_valid && in_stall) n_held++;
    if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall))) quiet_cycles = 0;
    else quiet_cycles++;
    out_stall <= hold_off || ($urandom_range(99) < stall_pct);
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("motor_can_frame_codec_core test failed");
      $finish;
    end
  end

  initial begin
    add_row(pack_req(POS_LO, VEL_LO, KP_LO, KD_LO, TRQ_LO), 1'b1, cmd_result('0));
    add_row(pack_req(POS_HI, VEL_HI, KP_HI, KD_HI, TRQ_HI), 1'b1, cmd_result('1));
    add_row(pack_req(POS_LO - 1, VEL_LO - 1, KP_LO, KD_LO, TRQ_LO - 1), 1'b1,
            cmd_result('0));
    add_row(pack_req(POS_HI + 1, VEL_HI + 1, KP_HI + 1, KD_HI + 1, TRQ_HI + 1), 1'b1,
            cmd_result('1));
    add_row(pack_req(-1048576, -4194304, KP_LO, KD_LO, -1048576), 1'b1, cmd_result('0));
    add_row(pack_req(1048575, 4194303, 33554431, 524287, 1048575), 1'b1, cmd_result('1));
    add_row(pack_req(0, 0, 0, 0, 0), 1'b0, '0);
    add_row(pack_req(POS_HI - 1, VEL_HI - 1, KP_HI - 1, KD_HI - 1, TRQ_HI - 1), 1'b0, '0);
    add_row(pack_req(POS_LO + 1, VEL_LO + 1, 1, 1, TRQ_LO + 1), 1'b0, '0);
    add_row(pack_req(POS_LO, VEL_HI, KP_LO, KD_HI, TRQ_LO), 1'b0, '0);
    add_row(pack_req(-81920, 655360, 16384000, 65536, 32768), 1'b0, '0);
    add_row(unpack_req('0), 1'b1, reply_result(8'h00, POS_LO, VEL_LO, TRQ_LO, 8'h00, 8'h00));
    add_row(unpack_req('1), 1'b1, reply_result(8'hFF, POS_HI, VEL_HI, TRQ_HI, 8'hFF, 8'hFF));
    add_row(unpack_req(64'hA5A5_A5A5_A5A5_A5A5), 1'b0, '0);
    add_row(unpack_req(64'h5A5A_5A5A_5A5A_5A5A), 1'b0, '0);
    add_row(unpack_req(64'h7F80_0080_0800_3C01), 1'b0, '0);
    add_row(unpack_req(64'h0100_0100_1001_0203), 1'b0, '0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_request(directed_rows[i].req, directed_rows[i].known, directed_rows[i].want);

    run_phase(170, 0, 0);
    run_phase(170, 51, 0);
    run_phase(170, 0, 51);
    run_phase(170, 18, 18);

    // The receiver holds off for a long stretch while requests keep coming, so
    // that the pipeline fills and the input side has to stall.
    send_gap_pct = 0;
    stall_pct   <= 0;
    fork
      begin
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
      end
    join_none
    repeat (40) send_request(random_request(), 1'b0, '0);

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Covered %0d pack and %0d unpack requests with saturation and code extremes,",
             n_pack, n_unpack);
    $display("%0d results compared, input held off in %0d cycles, %0d field mismatches.",
             n_checked, n_held, n_errors);
    if (n_errors == 0 && pending_results.size() == 0) begin
      $display("motor_can_frame_codec_core test passed");
    end else begin
      $display("motor_can_frame_codec_core test failed");
    end
    $finish;
  end

endmodule
